/* rtl/core/emcsr_pkg.sv */
// ----------------------------------------------------------------------------
// emcsr_pkg
// Shared types and constants of the MAC register block: word indices,
// action codes, management frame constants and the store request.
// ----------------------------------------------------------------------------
package emcsr_pkg;

  // action codes of an input beat
  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_RAISE = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  // register word indices
  localparam logic [7:0] W_ID      = 8'd0;
  localparam logic [7:0] W_EVENTS  = 8'd1;
  localparam logic [7:0] W_MASK    = 8'd2;
  localparam logic [7:0] W_CONTROL = 8'd9;
  localparam logic [7:0] W_FRAME   = 8'd16;
  localparam logic [7:0] W_ADDR_LO = 8'd57;
  localparam logic [7:0] W_ADDR_HI = 8'd58;

  // configuration register indices
  localparam logic CFG_PHY_ADDRESS     = 1'b0;
  localparam logic CFG_STATION_ADDRESS = 1'b1;

  // event and control bits
  localparam logic [31:0] EV_MII     = 32'h0080_0000;
  localparam logic [31:0] CTL_RESET  = 32'h0000_0001;
  localparam logic [31:0] CTL_ENABLE = 32'h0000_0002;

  // management frame operations and constants
  localparam logic [1:0]  MDIO_OP_WRITE   = 2'd1;
  localparam logic [1:0]  MDIO_OP_READ    = 2'd2;
  localparam logic [4:0]  PHY_REG_CONTROL = 5'd0;
  localparam logic [4:0]  PHY_REG_STATUS  = 5'd1;
  localparam logic [15:0] PHY_CTL_DEFAULT = 16'h3101;
  localparam logic [15:0] PHY_STATUS      = 16'h782D;
  localparam logic [15:0] PHY_MISS_DATA   = 16'hFFFF;
  localparam logic [15:0] ADDR_HI_LOW     = 16'h8808;

  // request to the word store
  typedef struct packed {
    logic        wr_en;
    logic        rd_en;
    logic [7:0]  addr;
    logic [31:0] wdata;
  } store_req_t;

endpackage

/* rtl/core/emcsr_store.sv */
// ----------------------------------------------------------------------------
// emcsr_store
// Synchronous word store with a registered read and a valid bit
// per word; a word never written since reset reads as zero.
// ----------------------------------------------------------------------------
module emcsr_store #(
  parameter int WORDS = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  emcsr_pkg::store_req_t req,
  output logic [31:0]           rd_data
);

  localparam int AW = $clog2(WORDS);

  logic [31:0]      mem_r [WORDS];
  logic [WORDS-1:0] valid_r;
  logic [31:0]      q_r;
  logic             q_valid_r;
  logic [AW-1:0]    addr;

  assign addr = req.addr[AW-1:0];

  // memory array, write and registered read
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[addr] <= req.wdata;
    end
    if (req.rd_en) begin
      q_r <= mem_r[addr];
    end
  end

  // written marks, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= '0;
      q_valid_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        valid_r[addr] <= 1'b1;
      end
      if (req.rd_en) begin
        q_valid_r <= valid_r[addr];
      end
    end
  end

  assign rd_data = q_valid_r ? q_r : 32'h0;

endmodule

/* rtl/core/ethernet_mac_csr_mii_block_top.sv */
// ----------------------------------------------------------------------------
// ethernet_mac_csr_mii_block_top
// Register block of an Ethernet MAC with a management frame port to one
// modelled PHY.
// ----------------------------------------------------------------------------
// Takes one beat per clock cycle with no bubbles while out_tready is high; each
// beat gives exactly one result beat, through the registered word store read
// and then the output register. Event, mask, PHY control and
// the two station address words live in flops; all other words are held in a
// single-port synchronous store whose words read as zero until written, so no
// clearing pass is needed after reset. The store is written in the cycle a
// beat is accepted, so a read in the next cycle already sees it.
module ethernet_mac_csr_mii_block_top #(
  parameter int REGISTER_WORDS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [47:0] cfg_wr_data,
  // input beats
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // action[1:0], word_index[9:2],
                                  // write_data[41:10], event_bits[73:42]
  // result beats
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // read_data[31:0], irq_level[32]
);

  // input fields
  logic [1:0]  in_action;
  logic [7:0]  in_word_index;
  logic [31:0] in_write_data;
  logic [31:0] in_event_bits;

  assign in_action     = in_tdata[1:0];
  assign in_word_index = in_tdata[9:2];
  assign in_write_data = in_tdata[41:10];
  assign in_event_bits = in_tdata[73:42];

  // state in flops
  logic [4:0]  mgmt_addr_r;
  logic [31:0] addr_lo_r, addr_lo_nxt;
  logic [31:0] addr_hi_r, addr_hi_nxt;
  logic [31:0] events_r, events_nxt;
  logic [31:0] mask_r, mask_nxt;
  logic [15:0] phy_ctl_r, phy_ctl_nxt;

  // pipeline
  logic        s1_valid_r;
  logic        s1_from_mem_r;
  logic [31:0] s1_data_r;
  logic        s1_irq_r;
  logic        out_valid_r;
  logic [31:0] out_data_r;
  logic        out_irq_r;

  logic        accept;
  logic        s1_go;
  logic        in_range;
  logic        is_read;
  logic        is_write;
  logic        from_mem;
  logic [31:0] direct_data;

  emcsr_pkg::store_req_t store_req;
  logic [31:0]           store_rd;

  // handshake
  assign s1_go     = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_go;
  assign accept    = in_tvalid && in_tready;

  assign in_range = (32'(in_word_index) < REGISTER_WORDS);
  assign is_read  = (in_action == emcsr_pkg::ACT_READ) && in_range;
  assign is_write = (in_action == emcsr_pkg::ACT_WRITE) && in_range;

  // management frame decode
  logic [1:0]  fr_op;
  logic [4:0]  fr_pa;
  logic [4:0]  fr_ra;
  logic [15:0] fr_data;
  logic [31:0] frame_word;

  assign fr_op   = in_write_data[29:28];
  assign fr_pa   = in_write_data[27:23];
  assign fr_ra   = in_write_data[22:18];
  assign fr_data = in_write_data[15:0];

  // register update of one beat
  always_comb begin
    events_nxt  = events_r;
    mask_nxt    = mask_r;
    phy_ctl_nxt = phy_ctl_r;
    addr_lo_nxt = addr_lo_r;
    addr_hi_nxt = addr_hi_r;
    frame_word  = in_write_data;
    store_req   = '{wr_en: 1'b0, rd_en: 1'b0, addr: in_word_index,
                    wdata: in_write_data};
    from_mem    = 1'b0;
    direct_data = 32'h0;

    // frame transaction result
    if (fr_pa == mgmt_addr_r) begin
      if (fr_op == emcsr_pkg::MDIO_OP_WRITE) begin
        if (fr_ra == emcsr_pkg::PHY_REG_CONTROL) begin
          phy_ctl_nxt = fr_data[15] ? emcsr_pkg::PHY_CTL_DEFAULT : fr_data;
        end
      end else if (fr_op == emcsr_pkg::MDIO_OP_READ) begin
        if (fr_ra == emcsr_pkg::PHY_REG_CONTROL) begin
          frame_word = {in_write_data[31:16], phy_ctl_r};
        end else if (fr_ra == emcsr_pkg::PHY_REG_STATUS) begin
          frame_word = {in_write_data[31:16], emcsr_pkg::PHY_STATUS};
        end else begin
          frame_word = {in_write_data[31:16], 16'h0};
        end
      end
    end else if (fr_op == emcsr_pkg::MDIO_OP_READ) begin
      frame_word = {in_write_data[31:16], emcsr_pkg::PHY_MISS_DATA};
    end

    if (accept) begin
      // reads
      if (is_read) begin
        case (in_word_index)
          emcsr_pkg::W_ID:      direct_data = 32'h0;
          emcsr_pkg::W_EVENTS:  direct_data = events_r;
          emcsr_pkg::W_MASK:    direct_data = mask_r;
          emcsr_pkg::W_ADDR_LO: direct_data = addr_lo_r;
          emcsr_pkg::W_ADDR_HI: direct_data = addr_hi_r;
          default: begin
            from_mem        = 1'b1;
            store_req.rd_en = 1'b1;
          end
        endcase
      end

      // writes
      if (is_write) begin
        case (in_word_index)
          emcsr_pkg::W_EVENTS:  events_nxt  = events_r & ~in_write_data;
          emcsr_pkg::W_MASK:    mask_nxt    = in_write_data;
          emcsr_pkg::W_ADDR_LO: addr_lo_nxt = in_write_data;
          emcsr_pkg::W_ADDR_HI: addr_hi_nxt = in_write_data;
          emcsr_pkg::W_CONTROL: begin
            store_req.wr_en = 1'b1;
            if ((in_write_data & emcsr_pkg::CTL_RESET) != 32'h0) begin
              store_req.wdata = in_write_data &
                                ~(emcsr_pkg::CTL_ENABLE | emcsr_pkg::CTL_RESET);
              events_nxt      = 32'h0;
            end
          end
          emcsr_pkg::W_FRAME: begin
            store_req.wr_en = 1'b1;
            store_req.wdata = frame_word;
            events_nxt      = events_r | emcsr_pkg::EV_MII;
          end
          default: store_req.wr_en = 1'b1;
        endcase
      end

      // event raise
      if (in_action == emcsr_pkg::ACT_RAISE) begin
        events_nxt = events_r | in_event_bits;
      end
    end

    // phy control only changes on an accepted frame write
    if (!(accept && is_write && (in_word_index == emcsr_pkg::W_FRAME))) begin
      phy_ctl_nxt = phy_ctl_r;
    end

    // station address reload from configuration
    if (cfg_wr_en && (cfg_index == emcsr_pkg::CFG_STATION_ADDRESS)) begin
      addr_lo_nxt = cfg_wr_data[47:16];
      addr_hi_nxt = {cfg_wr_data[15:0], emcsr_pkg::ADDR_HI_LOW};
    end
  end

  // word store
  emcsr_store #(
    .WORDS (REGISTER_WORDS)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (store_req),
    .rd_data (store_rd)
  );

  // flop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mgmt_addr_r <= 5'd0;
      addr_lo_r   <= 32'h0;
      addr_hi_r   <= {16'h0, emcsr_pkg::ADDR_HI_LOW};
      events_r    <= 32'h0;
      mask_r      <= 32'h0;
      phy_ctl_r   <= emcsr_pkg::PHY_CTL_DEFAULT;
    end else begin
      if (cfg_wr_en && (cfg_index == emcsr_pkg::CFG_PHY_ADDRESS)) begin
        mgmt_addr_r <= cfg_wr_data[4:0];
      end
      addr_lo_r <= addr_lo_nxt;
      addr_hi_r <= addr_hi_nxt;
      events_r  <= events_nxt;
      mask_r    <= mask_nxt;
      phy_ctl_r <= phy_ctl_nxt;
    end
  end

  // read stage control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  // read stage payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_from_mem_r <= from_mem;
      s1_data_r     <= direct_data;
      s1_irq_r      <= |(events_nxt & mask_nxt);
    end
  end

  // output register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_data_r <= s1_from_mem_r ? store_rd : s1_data_r;
      out_irq_r  <= s1_irq_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'h0, out_irq_r, out_data_r};

endmodule
